[sv/splr_pkg.sv]
// Shared constants, types and helpers of the sample player resampler.
`timescale 1ns / 1ps

package splr_pkg;

    // Sample memory geometry (depth is a power of two; reads wrap modulo the depth).
    localparam int SAMPLE_DEPTH = 65536;
    localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
    // Word addresses of a frame pair are formed on at least 17 bits before wrapping.
    localparam int WADDR_W      = (ADDR_W > 17) ? ADDR_W : 17;
    // Width that holds both a load address and the depth itself.
    localparam int LIM_W        = (ADDR_W + 1 > 17) ? ADDR_W + 1 : 17;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_PLAY_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOTAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_GAIN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_GAIN  = 3'd7;

    // Request codes on req_type, also used as command kinds in the queue.
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_FRAME  = 2'd1;
    localparam logic [1:0] REQ_REWIND = 2'd2;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Unity gain in Q1.15.
    localparam logic [15:0] GAIN_ONE = 16'd32768;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        addr;
        logic signed [15:0] value;
    } cmd_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic        play_enable;
        logic        loop_enable;
        logic        stereo;
        logic [16:0] frame_total;
        logic [23:0] phase_step;
        logic [15:0] volume;
        logic [15:0] left_gain;
        logic [15:0] right_gain;
    } cfg_t;

    // Gains above one saturate at one.
    function automatic logic [15:0] sat_gain(input logic [15:0] g);
        return (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

endpackage

[sv/splr_front.sv]
// Front end: accepts request words, classifies them and pushes commands into the queue.
`timescale 1ns / 1ps

module splr_front
    import splr_pkg::*;
(
    input  logic               start,
    input  logic [1:0]         req_type,
    input  logic [15:0]        load_addr,
    input  logic signed [15:0] load_value,
    input  q_stat_t            q_stat,
    output logic               busy,
    output logic               push,
    output cmd_t               push_word
);

    logic accept;

    // A word is taken whenever the queue has room.
    assign busy   = q_stat.full;
    assign accept = start && !q_stat.full;

    // Loads outside the store and unused codes are dropped here.
    always_comb
    begin
        push            = 1'b0;
        push_word.kind  = req_type;
        push_word.addr  = load_addr;
        push_word.value = load_value;
        case (req_type)
            REQ_LOAD:   push = accept && (LIM_W'(load_addr) < LIM_W'(SAMPLE_DEPTH));
            REQ_FRAME:  push = accept;
            REQ_REWIND: push = accept;
            default:    push = 1'b0;
        endcase
    end

endmodule

[sv/splr_queue.sv]
// Short command queue that decouples the front end from the playback engine.
`timescale 1ns / 1ps

module splr_queue
    import splr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_word,
    input  logic    pop,
    output cmd_t    head_word,
    output q_stat_t q_stat
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign do_push          = push && (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign do_pop           = pop && (count_reg != '0);
    assign head_word        = entry_reg[rd_ptr_reg];
    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.full      = (count_reg == QCNT_W'(QUEUE_DEPTH));

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage carries no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

[sv/splr_engine.sv]
// Playback engine: sample memory, play head, interpolation and gain scaling.
`timescale 1ns / 1ps

module splr_engine
    import splr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  q_stat_t            q_stat,
    input  cmd_t               head_word,
    output logic               pop,
    output logic               done,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    output logic               active
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RDL  = 3'd1;
    localparam logic [2:0] ST_RDR  = 3'd2;
    localparam logic [2:0] ST_MULL = 3'd3;
    localparam logic [2:0] ST_MULR = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [32:0]         head_reg, head_next;

    logic [15:0]         sample_mem [SAMPLE_DEPTH];
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ADDR_W-1:0]   raddr0, raddr1;
    logic signed [15:0]  rd0_reg, rd1_reg;

    logic [ADDR_W-1:0]   addr_a_reg, addr_b_reg, addr_a2_reg, addr_b2_reg;
    logic [15:0]         frac_reg;
    logic [31:0]         gprod_l_reg, gprod_r_reg;
    logic signed [31:0]  interp_l_reg, interp_r_reg;
    logic signed [63:0]  p_l_reg, p_r_reg;

    logic                done_reg, active_reg;
    logic signed [15:0]  left_reg, right_reg;

    logic                dispatch, is_frame, silent, has_next;
    logic [16:0]         frame, next_frame;
    logic [WADDR_W-1:0]  base_a, base_b, base_a2, base_b2;
    logic [32:0]         head_adv;
    logic signed [16:0]  diff;
    logic signed [33:0]  diff_frac;
    logic signed [33:0]  interp_sum;
    logic signed [31:0]  interp_now;
    logic signed [15:0]  left_now, right_now;

    assign dispatch = (state_reg == ST_IDLE) && q_stat.not_empty;
    assign pop      = dispatch;
    assign is_frame = dispatch && (head_word.kind == REQ_FRAME);

    // Frame selection from the play head.
    always_comb
    begin
        frame      = head_reg[32:16];
        silent     = !cfg.play_enable || (frame >= cfg.frame_total);
        has_next   = ({1'b0, frame} + 18'd1) < {1'b0, cfg.frame_total};
        next_frame = has_next ? frame + 17'd1 : frame;
        base_a     = cfg.stereo ? WADDR_W'({frame, 1'b0}) : WADDR_W'(frame);
        base_b     = cfg.stereo ? WADDR_W'({next_frame, 1'b0}) : WADDR_W'(next_frame);
        base_a2    = cfg.stereo ? base_a + 1'b1 : base_a;
        base_b2    = cfg.stereo ? base_b + 1'b1 : base_b;
        head_adv   = head_reg + 33'(cfg.phase_step);
    end

    // Linear interpolation of the two words held in the read registers.
    always_comb
    begin
        diff       = {rd1_reg[15], rd1_reg} - {rd0_reg[15], rd0_reg};
        diff_frac  = diff * $signed({1'b0, frac_reg});
        interp_sum = $signed({{2{rd0_reg[15]}}, rd0_reg, 16'h0000}) + diff_frac;
        interp_now = interp_sum[31:0];
    end

    // Truncation toward zero of the scaled products.
    always_comb
    begin
        logic signed [63:0] q_l;
        logic signed [63:0] q_r;
        q_l       = p_l_reg + (p_l_reg[63] ? 64'sh3FFF_FFFF_FFFF : 64'sh0);
        q_r       = p_r_reg + (p_r_reg[63] ? 64'sh3FFF_FFFF_FFFF : 64'sh0);
        left_now  = q_l[61:46];
        right_now = q_r[61:46];
    end

    // Sequencer and play head.
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (dispatch)
                begin
                    if (head_word.kind == REQ_REWIND)
                    begin
                        head_next = '0;
                    end
                    else if (is_frame && !silent)
                    begin
                        state_next = ST_RDL;
                        if (cfg.loop_enable && (head_adv[32:16] >= cfg.frame_total))
                        begin
                            head_next = '0;
                        end
                        else
                        begin
                            head_next = head_adv;
                        end
                    end
                end
            end
            ST_RDL:  state_next = ST_RDR;
            ST_RDR:  state_next = ST_MULL;
            ST_MULL: state_next = ST_MULR;
            ST_MULR: state_next = ST_FIN;
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            done_reg   <= 1'b0;
            active_reg <= 1'b0;
            left_reg   <= '0;
            right_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            done_reg  <= 1'b0;
            if (is_frame && silent)
            begin
                done_reg   <= 1'b1;
                active_reg <= 1'b0;
                left_reg   <= '0;
                right_reg  <= '0;
            end
            else if (state_reg == ST_FIN)
            begin
                done_reg   <= 1'b1;
                active_reg <= 1'b1;
                left_reg   <= left_now;
                right_reg  <= right_now;
            end
        end
    end

    // Sample memory: one write port, two registered read ports.
    assign mem_we    = dispatch && (head_word.kind == REQ_LOAD);
    assign mem_waddr = ADDR_W'(WADDR_W'(head_word.addr));
    assign raddr0    = (state_reg == ST_RDL) ? addr_a_reg : addr_a2_reg;
    assign raddr1    = (state_reg == ST_RDL) ? addr_b_reg : addr_b2_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[mem_waddr] <= head_word.value;
        end
        rd0_reg <= sample_mem[raddr0];
        rd1_reg <= sample_mem[raddr1];
    end

    // Datapath registers: addresses, combined gains, interpolation and products.
    always_ff @(posedge clk)
    begin
        gprod_l_reg <= sat_gain(cfg.volume) * sat_gain(cfg.left_gain);
        gprod_r_reg <= sat_gain(cfg.volume) * sat_gain(cfg.right_gain);
        if (is_frame)
        begin
            addr_a_reg  <= base_a[ADDR_W-1:0];
            addr_b_reg  <= base_b[ADDR_W-1:0];
            addr_a2_reg <= base_a2[ADDR_W-1:0];
            addr_b2_reg <= base_b2[ADDR_W-1:0];
            frac_reg    <= has_next ? head_reg[15:0] : 16'h0000;
        end
        if (state_reg == ST_RDR)
        begin
            interp_l_reg <= interp_now;
        end
        if (state_reg == ST_MULL)
        begin
            interp_r_reg <= interp_now;
            p_l_reg      <= interp_l_reg * $signed({1'b0, gprod_l_reg[30:0]});
        end
        if (state_reg == ST_MULR)
        begin
            p_r_reg <= interp_r_reg * $signed({1'b0, gprod_r_reg[30:0]});
        end
    end

    assign done      = done_reg;
    assign active    = active_reg;
    assign left_out  = left_reg;
    assign right_out = right_reg;

endmodule

[sv/sample_player_lerp_resampler.sv]
// Top level of the sample player: configuration registers, front end, queue and engine.
`timescale 1ns / 1ps

// Sample player with linear interpolation between neighboring frames.
// Request words enter on start/busy: a word is taken at a clock edge where start
// is high and busy is low. req_type selects a sample load, a frame request or a
// rewind. Loads and rewinds give no result; each frame request gives one result
// word on left_out/right_out/active, marked by done for exactly one cycle.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must do so only
// while the block is idle, as the block does not enforce this. A frame request passes
// through the queue; a silent one (paused or past the end) sets done when popped, an
// active one after ST_RDL and ST_RDR (reads of the two-port sample memory, left pair,
// then right pair), ST_MULL and ST_MULR (gain products, one per channel) and ST_FIN.
// Loads and rewinds are done in the idle state. A two-word command queue lets the front
// end keep taking words while the engine works; busy is high when the queue is full.
// Reset clears the play head, the queue and the configuration to its defaults;
// sample memory is not cleared and holds garbage until loaded.
// The receiver cannot stall: each result is presented once and must be taken.
module sample_player_lerp_resampler
    import splr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            req_type,
    input  logic [15:0]           load_addr,
    input  logic signed [15:0]    load_value,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic signed [15:0]    left_out,
    output logic signed [15:0]    right_out,
    output logic                  active
);

    cfg_t    cfg_reg;
    q_stat_t q_stat;
    logic    push, pop;
    cmd_t    push_word, head_word;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.play_enable <= 1'b0;
            cfg_reg.loop_enable <= 1'b0;
            cfg_reg.stereo      <= 1'b0;
            cfg_reg.frame_total <= '0;
            cfg_reg.phase_step  <= 24'd65536;
            cfg_reg.volume      <= 16'd16384;
            cfg_reg.left_gain   <= 16'd23170;
            cfg_reg.right_gain  <= 16'd23170;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PLAY_ENABLE: cfg_reg.play_enable <= cfg_data[0];
                REG_LOOP_ENABLE: cfg_reg.loop_enable <= cfg_data[0];
                REG_STEREO:      cfg_reg.stereo      <= cfg_data[0];
                REG_FRAME_TOTAL: cfg_reg.frame_total <= cfg_data[16:0];
                REG_PHASE_STEP:  cfg_reg.phase_step  <= cfg_data[23:0];
                REG_VOLUME:      cfg_reg.volume      <= cfg_data[15:0];
                REG_LEFT_GAIN:   cfg_reg.left_gain   <= cfg_data[15:0];
                REG_RIGHT_GAIN:  cfg_reg.right_gain  <= cfg_data[15:0];
                default:         cfg_reg.play_enable <= cfg_reg.play_enable;
            endcase
        end
    end

    // Request classification.
    splr_front u_front
    (
        .start      (start),
        .req_type   (req_type),
        .load_addr  (load_addr),
        .load_value (load_value),
        .q_stat     (q_stat),
        .busy       (busy),
        .push       (push),
        .push_word  (push_word)
    );

    // Command queue.
    splr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .pop        (pop),
        .head_word  (head_word),
        .q_stat     (q_stat)
    );

    // Playback engine.
    splr_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_stat     (q_stat),
        .head_word  (head_word),
        .pop        (pop),
        .done       (done),
        .left_out   (left_out),
        .right_out  (right_out),
        .active     (active)
    );

endmodule
